FILE: src/tpss_pkg.sv
// Shared constants and status types for the two-phase serial slave.
package tpss_pkg;

	// Default and range limits of the data word length
	localparam int WORD_BITS_DEFAULT = 32;
	localparam int FIELD_WORD_W      = 32;

	// Device identifier register
	localparam int         UID_W     = 8;
	localparam logic [7:0] UID_RESET = 8'd21;

	// Bit counters of the two engines
	localparam int         BUS_CNT_W    = 6;
	localparam int         ID_CNT_W     = 4;
	localparam logic [3:0] ID_END_COUNT = 4'd10;

	// Line drive codes
	localparam logic [1:0] DRV_RELEASED = 2'd0;
	localparam logic [1:0] DRV_LOW      = 2'd1;
	localparam logic [1:0] DRV_HIGH     = 2'd2;

	// Item opcodes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SEND = 1'b1;

	// Bus engine flags for one result beat
	typedef struct packed {
		logic drive_enable;
		logic drive_high;
		logic received_valid;
		logic uid_match;
		logic send_busy;
	} bus_status_t;

	// ID engine flags for one result beat
	typedef struct packed {
		logic drive_enable;
		logic drive_high;
	} id_status_t;

endpackage

FILE: src/tpss_id_engine.sv
// ID responder: waits for a request pulse, then sends one, the 8 ID bits and a closing one.
module tpss_id_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step_en,
	input  logic                      op,
	input  logic                      pin,
	input  logic [tpss_pkg::UID_W-1:0] uid,
	output tpss_pkg::id_status_t      status
);

	logic                          phase_q;
	logic [tpss_pkg::ID_CNT_W-1:0] cnt_q;
	logic [1:0]                    drv_q;

	logic                          phase_nx;
	logic [tpss_pkg::ID_CNT_W-1:0] cnt_nx;
	logic [1:0]                    drv_nx;
	logic [2:0]                    bit_idx;

	assign bit_idx = 3'(cnt_q - 4'd2);

	// Work out the next state for one tick
	always_comb begin
		phase_nx = phase_q;
		cnt_nx   = cnt_q;
		drv_nx   = drv_q;
		if (op == tpss_pkg::OP_TICK) begin
			if (phase_q) begin
				if (cnt_q == 4'd0) begin
					drv_nx = tpss_pkg::DRV_RELEASED;
					if (pin) begin
						cnt_nx = 4'd1;
					end
				end else if (cnt_q == 4'd1) begin
					drv_nx = tpss_pkg::DRV_HIGH;
					cnt_nx = 4'd2;
				end else if (cnt_q < tpss_pkg::ID_END_COUNT) begin
					drv_nx = uid[bit_idx] ? tpss_pkg::DRV_HIGH : tpss_pkg::DRV_LOW;
					cnt_nx = cnt_q + 4'd1;
				end else if (cnt_q == tpss_pkg::ID_END_COUNT) begin
					drv_nx = tpss_pkg::DRV_HIGH;
					cnt_nx = cnt_q + 4'd1;
				end else begin
					drv_nx = tpss_pkg::DRV_RELEASED;
					cnt_nx = 4'd0;
				end
				phase_nx = 1'b0;
			end else begin
				phase_nx = 1'b1;
				if (cnt_q == 4'd0) begin
					drv_nx = tpss_pkg::DRV_RELEASED;
					// request pulse starts the count and holds the phase at zero
					if (pin) begin
						cnt_nx   = 4'd1;
						phase_nx = 1'b0;
					end
				end
			end
		end
	end

	// Hold engine state between beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			cnt_q   <= '0;
			drv_q   <= tpss_pkg::DRV_RELEASED;
		end else if (step_en) begin
			phase_q <= phase_nx;
			cnt_q   <= cnt_nx;
			drv_q   <= drv_nx;
		end
	end

	assign status.drive_enable = (drv_nx == tpss_pkg::DRV_LOW) || (drv_nx == tpss_pkg::DRV_HIGH);
	assign status.drive_high   = (drv_nx == tpss_pkg::DRV_HIGH);

endmodule

FILE: src/tpss_bus_engine.sv
// Bus engine: two start bits, then a data word received or sent LSB first.
module tpss_bus_engine #(
	parameter int WORD_BITS = tpss_pkg::WORD_BITS_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step_en,
	input  logic                       op,
	input  logic [WORD_BITS-1:0]       load_word,
	input  logic                       pin,
	input  logic [tpss_pkg::UID_W-1:0] uid,
	output tpss_pkg::bus_status_t      status,
	output logic [WORD_BITS-1:0]       word
);

	localparam int IDX_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam logic [tpss_pkg::BUS_CNT_W-1:0] LAST = tpss_pkg::BUS_CNT_W'(WORD_BITS + 2);

	logic                           phase_q;
	logic [tpss_pkg::BUS_CNT_W-1:0] cnt_q;
	logic                           sending_q;
	logic [WORD_BITS-1:0]           word_q;
	logic [1:0]                     drv_q;

	logic                           phase_nx;
	logic [tpss_pkg::BUS_CNT_W-1:0] cnt_nx;
	logic                           sending_nx;
	logic [WORD_BITS-1:0]           word_nx;
	logic [1:0]                     drv_nx;
	logic                           done;
	logic                           one_bit;
	logic [IDX_W-1:0]               bit_idx;

	// pin low carries a logical one
	assign one_bit = ~pin;
	assign bit_idx = IDX_W'(cnt_q - 6'd2);

	// Work out the next state for one beat
	always_comb begin
		phase_nx   = phase_q;
		cnt_nx     = cnt_q;
		sending_nx = sending_q;
		word_nx    = word_q;
		drv_nx     = drv_q;
		done       = 1'b0;
		if (op == tpss_pkg::OP_SEND) begin
			cnt_nx     = '0;
			word_nx    = load_word;
			sending_nx = 1'b1;
		end else begin
			if (!phase_q) begin
				// sample phase
				if (sending_q) begin
					if (cnt_q == 6'd0) begin
						drv_nx = tpss_pkg::DRV_RELEASED;
						if (one_bit) begin
							cnt_nx   = 6'd1;
							phase_nx = 1'b1;
						end
					end
				end else if (cnt_q == 6'd0) begin
					drv_nx = tpss_pkg::DRV_RELEASED;
					if (one_bit) begin
						cnt_nx = 6'd1;
					end
				end else if (cnt_q == 6'd1) begin
					drv_nx = tpss_pkg::DRV_RELEASED;
					if (!one_bit) begin
						cnt_nx  = 6'd2;
						word_nx = '0;
					end else begin
						cnt_nx = 6'd0;
					end
				end else if (cnt_q < LAST) begin
					drv_nx  = tpss_pkg::DRV_RELEASED;
					word_nx = word_q | (WORD_BITS'(one_bit) << bit_idx);
					cnt_nx  = cnt_q + 6'd1;
				end else begin
					cnt_nx = 6'd0;
					done   = 1'b1;
				end
			end else begin
				// drive phase
				if (!sending_q) begin
					if (cnt_q == 6'd1) begin
						drv_nx = tpss_pkg::DRV_RELEASED;
						if (!one_bit) begin
							cnt_nx   = 6'd2;
							word_nx  = '0;
							phase_nx = 1'b0;
						end
					end
				end else if (cnt_q == 6'd0) begin
					drv_nx = tpss_pkg::DRV_RELEASED;
					if (one_bit) begin
						cnt_nx = 6'd1;
					end
				end else if (cnt_q == 6'd1) begin
					drv_nx = tpss_pkg::DRV_HIGH;
					cnt_nx = 6'd2;
				end else if (cnt_q < LAST) begin
					drv_nx = word_q[bit_idx] ? tpss_pkg::DRV_LOW : tpss_pkg::DRV_HIGH;
					cnt_nx = cnt_q + 6'd1;
				end else begin
					sending_nx = 1'b0;
					cnt_nx     = 6'd0;
				end
			end
			// toggle phase at the end of every tick
			phase_nx = ~phase_nx;
		end
	end

	// Hold engine state between beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 1'b1;
			cnt_q     <= '0;
			sending_q <= 1'b0;
			word_q    <= '0;
			drv_q     <= tpss_pkg::DRV_RELEASED;
		end else if (step_en) begin
			phase_q   <= phase_nx;
			cnt_q     <= cnt_nx;
			sending_q <= sending_nx;
			word_q    <= word_nx;
			drv_q     <= drv_nx;
		end
	end

	assign status.drive_enable   = (drv_nx == tpss_pkg::DRV_LOW) || (drv_nx == tpss_pkg::DRV_HIGH);
	assign status.drive_high     = (drv_nx == tpss_pkg::DRV_HIGH);
	assign status.received_valid = done;
	assign status.uid_match      = done && (word_nx == WORD_BITS'(uid));
	assign status.send_busy      = sending_nx;
	assign word                  = word_nx;

endmodule

FILE: src/two_phase_serial_slave_core.sv
// Top level of the two-phase single-wire bus slave with ID responder.
//
// Each input beat is either a timer tick (op 0) that samples the bus and ID pins
// and steps both engines, or a send request (op 1) that loads a word to transmit.
// Every accepted beat yields exactly one result beat with the line drives, the
// receive flags and the send status. The block takes one beat per clock cycle
// unless in_stall holds the input side; a beat is captured in the input register
// and moves on to the result register when the output side is not stalled, and
// the engine state update lies between those two registers. The identifier
// register uid_q is written over the configuration channel, which is always
// ready, and resets to 21.
module two_phase_serial_slave_core #(
	parameter int WORD_BITS = tpss_pkg::WORD_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// item channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              op,
	input  logic [tpss_pkg::FIELD_WORD_W-1:0] send_word,
	input  logic                              bus_pin,
	input  logic                              id_pin,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              bus_drive_enable,
	output logic                              bus_drive_high,
	output logic                              id_drive_enable,
	output logic                              id_drive_high,
	output logic                              received_valid,
	output logic [tpss_pkg::FIELD_WORD_W-1:0] received_word,
	output logic                              uid_match,
	output logic                              send_busy,
	// configuration channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tpss_pkg::UID_W-1:0]        cfg_data
);

	logic [tpss_pkg::UID_W-1:0] uid_q;

	logic                       valid_s1;
	logic                       op_s1;
	logic [WORD_BITS-1:0]       word_s1;
	logic                       bus_pin_s1;
	logic                       id_pin_s1;

	logic                       valid_s2;
	tpss_pkg::bus_status_t      bus_st_s2;
	tpss_pkg::id_status_t       id_st_s2;
	logic [WORD_BITS-1:0]       rx_word_s2;

	tpss_pkg::bus_status_t      bus_st;
	tpss_pkg::id_status_t       id_st;
	logic [WORD_BITS-1:0]       rx_word;
	logic                       advance;
	logic                       accept;
	logic                       step_en;

	// Advance when the result register is empty or being drained
	assign advance   = !valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign accept    = in_valid && !in_stall;
	assign step_en   = valid_s1 && advance;
	assign cfg_ready = 1'b1;

	// Write the identifier register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uid_q <= tpss_pkg::UID_RESET;
		end else if (cfg_valid && cfg_ready) begin
			uid_q <= cfg_data;
		end
	end

	// Track beats in the input and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Capture the input beat
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= op;
			word_s1    <= send_word[WORD_BITS-1:0];
			bus_pin_s1 <= bus_pin;
			id_pin_s1  <= id_pin;
		end
	end

	tpss_bus_engine #(
		.WORD_BITS (WORD_BITS)
	) u_bus (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.op        (op_s1),
		.load_word (word_s1),
		.pin       (bus_pin_s1),
		.uid       (uid_q),
		.status    (bus_st),
		.word      (rx_word)
	);

	tpss_id_engine u_id (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.op      (op_s1),
		.pin     (id_pin_s1),
		.uid     (uid_q),
		.status  (id_st)
	);

	// Load the result register
	always_ff @(posedge clk) begin
		if (step_en) begin
			bus_st_s2  <= bus_st;
			id_st_s2   <= id_st;
			rx_word_s2 <= rx_word;
		end
	end

	assign out_valid        = valid_s2;
	assign bus_drive_enable = bus_st_s2.drive_enable;
	assign bus_drive_high   = bus_st_s2.drive_high;
	assign received_valid   = bus_st_s2.received_valid;
	assign uid_match        = bus_st_s2.uid_match;
	assign send_busy        = bus_st_s2.send_busy;
	assign id_drive_enable  = id_st_s2.drive_enable;
	assign id_drive_high    = id_st_s2.drive_high;
	assign received_word    = tpss_pkg::FIELD_WORD_W'(rx_word_s2);

endmodule

FILE: src/tpss_checker.sv
// Port-level checks for the two-phase serial slave, bound to the top level.
module tpss_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic                              bus_drive_enable,
	input logic                              bus_drive_high,
	input logic                              id_drive_enable,
	input logic                              id_drive_high,
	input logic                              received_valid,
	input logic [tpss_pkg::FIELD_WORD_W-1:0] received_word,
	input logic                              uid_match,
	input logic                              send_busy
);

	// Keep a stalled result beat valid with its received word stable
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(received_word))
		else $error("result beat changed while stalled");

	// Drive high only on a driven bus line
	a_bus_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bus_drive_high |-> bus_drive_enable)
		else $error("bus driven high while released");

	// Drive high only on a driven ID line
	a_id_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && id_drive_high |-> id_drive_enable)
		else $error("ID line driven high while released");

	// Flag a match only with a completed word
	a_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && uid_match |-> received_valid)
		else $error("uid match without received word");

	// Complete a word only in receive mode
	a_rx_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && received_valid |-> !send_busy)
		else $error("word received while sending");

endmodule

bind two_phase_serial_slave_core tpss_checker u_tpss_checker (.*);
